// ===== rtl/pdscd_pkg.sv =====
// Shared types and constants of the source capabilities decoder.
package pdscd_pkg;

  localparam int SLOT_COUNT   = 8;
  localparam int BUFFER_BYTES = 48;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int OUT_DEPTH    = 2;

  localparam logic       KIND_FIXED   = 1'b0;
  localparam logic       KIND_PPS     = 1'b1;
  localparam logic [1:0] PDO_FIXED    = 2'b00;
  localparam logic [1:0] PDO_APDO     = 2'b11;
  localparam logic [1:0] APDO_SPR_PPS = 2'b00;

  localparam logic [15:0] FIXED_MV_LSB = 16'd50;
  localparam logic [13:0] FIXED_MA_LSB = 14'd10;
  localparam logic [15:0] PPS_MV_LSB   = 16'd100;
  localparam logic [14:0] PPS_MIN_LSB  = 15'd100;
  localparam logic [13:0] PPS_MA_LSB   = 14'd50;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_req;
  } pdscd_in_t;

  typedef struct packed {
    logic        entry_kind;
    logic [2:0]  slot;
    logic [15:0] voltage_mv;
    logic [14:0] min_voltage_mv;
    logic [13:0] max_current_ma;
    logic        pps_pwr_lim;
    logic        final_object;
  } pdscd_out_t;

  // Decode request from the front end: raw object bits plus slot bookkeeping.
  typedef struct packed {
    logic        entry_kind;
    logic [2:0]  slot;
    logic        final_object;
    logic [27:0] pdo;
  } pdscd_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pdscd_qstat_t;

endpackage

// ===== rtl/pdscd_front.sv =====
// Byte tracker: assembles data objects, classifies them and assigns slots.
module pdscd_front
  import pdscd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  pdscd_in_t  in_data,
  output logic       req_push,
  output pdscd_req_t req_data
);

  logic [5:0]  pos_r, pos_nxt;
  logic [2:0]  total_r, total_nxt;
  logic [23:0] word_r, word_nxt;
  logic [3:0]  fixed_cnt_r, fixed_cnt_nxt;
  logic [3:0]  pps_cnt_r, pps_cnt_nxt;

  always_comb begin
    logic [5:0]  off;
    logic [3:0]  idx;
    logic [1:0]  sub;
    logic [31:0] pdo;
    logic        is_fixed;
    logic        is_pps;
    logic        last;
    off           = pos_r - 6'd2;
    idx           = off[5:2];
    sub           = off[1:0];
    pdo           = {in_data.byte_value, word_r};
    is_fixed      = (pdo[31:30] == PDO_FIXED);
    is_pps        = (pdo[31:30] == PDO_APDO) && (pdo[29:28] == APDO_SPR_PPS);
    last          = (4'(idx + 4'd1) == {1'b0, total_r});
    pos_nxt       = pos_r;
    total_nxt     = total_r;
    word_nxt      = word_r;
    fixed_cnt_nxt = fixed_cnt_r;
    pps_cnt_nxt   = pps_cnt_r;
    req_push      = 1'b0;
    req_data      = '{entry_kind: KIND_FIXED, slot: fixed_cnt_r[2:0],
                      final_object: last, pdo: pdo[27:0]};
    if (accept) begin
      if (in_data.start_req) begin
        word_nxt      = {16'd0, in_data.byte_value};
        total_nxt     = 3'd0;
        fixed_cnt_nxt = 4'd0;
        pps_cnt_nxt   = 4'd0;
        pos_nxt       = 6'd1;
      end else if (pos_r != 6'd0 && pos_r < 6'(BUFFER_BYTES)) begin
        if (pos_r == 6'd1) begin
          total_nxt = in_data.byte_value[6:4];
        end else if (idx < {1'b0, total_r}) begin
          case (sub)
            2'd0: word_nxt = {16'd0, in_data.byte_value};
            2'd1: word_nxt[15:8] = in_data.byte_value;
            2'd2: word_nxt[23:16] = in_data.byte_value;
            default: begin
              if (is_fixed && fixed_cnt_r < 4'(SLOT_COUNT)) begin
                req_push      = 1'b1;
                fixed_cnt_nxt = fixed_cnt_r + 4'd1;
              end else if (is_pps && pps_cnt_r < 4'(SLOT_COUNT)) begin
                req_push            = 1'b1;
                req_data.entry_kind = KIND_PPS;
                req_data.slot       = pps_cnt_r[2:0];
                pps_cnt_nxt         = pps_cnt_r + 4'd1;
              end
            end
          endcase
        end
        pos_nxt = pos_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (!rst_n) begin
      pos_r       <= 6'd0;
      total_r     <= 3'd0;
      fixed_cnt_r <= 4'd0;
      pps_cnt_r   <= 4'd0;
    end else begin
      pos_r       <= pos_nxt;
      total_r     <= total_nxt;
      fixed_cnt_r <= fixed_cnt_nxt;
      pps_cnt_r   <= pps_cnt_nxt;
    end
  end

endmodule

// ===== rtl/pdscd_fifo.sv =====
// Short request queue between the byte tracker and the decode stage.
module pdscd_fifo
  import pdscd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  pdscd_req_t   push_data,
  input  logic         pop,
  output pdscd_req_t   pop_data,
  output pdscd_qstat_t stat
);

  pdscd_req_t         mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= FIFO_AW'(32'(wr_ptr_r) + 1 == FIFO_DEPTH ? 0 : 32'(wr_ptr_r) + 1);
      end
      if (do_pop) begin
        rd_ptr_r <= FIFO_AW'(32'(rd_ptr_r) + 1 == FIFO_DEPTH ? 0 : 32'(rd_ptr_r) + 1);
      end
      cnt_r <= cnt_r + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
    end
  end

endmodule

// ===== rtl/pdscd_back.sv =====
// Decode stage: scales object fields and holds results in a two-entry output buffer.
module pdscd_back
  import pdscd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  pdscd_qstat_t q_stat,
  input  pdscd_req_t   q_data,
  output logic         q_pop,
  input  logic         out_pop,
  output logic         out_empty,
  output pdscd_out_t   out_data
);

  pdscd_out_t ent_r [OUT_DEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       take, give;
  pdscd_out_t res;

  assign out_empty = (cnt_r == 2'd0);
  assign give      = out_pop && !out_empty;
  assign take      = !q_stat.empty && (cnt_r != 2'(OUT_DEPTH));
  assign q_pop     = take;
  assign out_data  = ent_r[rd_ptr_r];

  always_comb begin
    res.entry_kind   = q_data.entry_kind;
    res.slot         = q_data.slot;
    res.final_object = q_data.final_object;
    if (q_data.entry_kind == KIND_PPS) begin
      res.voltage_mv     = 16'(q_data.pdo[24:17]) * PPS_MV_LSB;
      res.min_voltage_mv = 15'(q_data.pdo[15:8]) * PPS_MIN_LSB;
      res.max_current_ma = 14'(q_data.pdo[6:0]) * PPS_MA_LSB;
      res.pps_pwr_lim    = q_data.pdo[27];
    end else begin
      res.voltage_mv     = 16'(q_data.pdo[19:10]) * FIXED_MV_LSB;
      res.min_voltage_mv = 15'd0;
      res.max_current_ma = 14'(q_data.pdo[9:0]) * FIXED_MA_LSB;
      res.pps_pwr_lim    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ent_r[wr_ptr_r] <= res;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (take) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (give) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(take) - 2'(give);
    end
  end

endmodule

// ===== rtl/pd_source_caps_decoder_core.sv =====
// Top level of the source capabilities decoder: tracker, request queue and decode stage.
// Throughput: one byte per cycle; in_full rises only while the request queue holds
//   four undecoded objects, which happens only when the result side stops popping.
// Path: the request for a result is written into the request queue at the edge that accepts
//   its fourth object byte, then moves into the decode stage's output buffer, which drives the
//   out_ ports; while that buffer is full, the request waits in the queue.
// Reset: synchronous, active low; clears byte position, object count, slot counts and
//   both queues. No memory needs a clearing pass, so bytes are taken from the next cycle.
module pd_source_caps_decoder_core
  import pdscd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  pdscd_in_t  in_data,
  output logic       out_empty,
  input  logic       out_pop,
  output pdscd_out_t out_data
);

  logic         accept;
  logic         req_push;
  pdscd_req_t   req_data;
  logic         q_pop;
  pdscd_req_t   q_data;
  pdscd_qstat_t q_stat;

  // Hold off the source only when the request queue could not take an object.
  assign in_full = q_stat.full;
  assign accept  = in_push && !in_full;

  // Front end: track the byte position, assemble objects, assign slots.
  pdscd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_data  (in_data),
    .req_push (req_push),
    .req_data (req_data)
  );

  // Decouple the tracker from the decode stage so each can stall on its own.
  pdscd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (req_push),
    .push_data (req_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  // Back end: scale the fields and present each result as a request on the out_ side.
  pdscd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

  // A decode request must never be raised while the queue is full.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    req_push |-> !q_stat.full)
    else $error("decode request raised while request queue full");

  // A fixed entry carries no minimum voltage and no power-limited flag.
  a_fixed_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.entry_kind == KIND_FIXED)
      |-> (out_data.min_voltage_mv == 15'd0 && !out_data.pps_pwr_lim))
    else $error("fixed entry with PPS-only fields set");

  // A waiting result that is not popped holds.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed without a pop");

  // A start byte never produces a decode request.
  a_start_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.start_req) |-> !req_push)
    else $error("decode request on a start byte");

endmodule

// ===== bench/pd_source_caps_decoder_core_tb.sv =====
// Testbench for the source capabilities decoder: byte stream stimulus, decode prediction, result checks.
`timescale 1ns / 1ps

module pd_source_caps_decoder_core_tb;
  import pdscd_pkg::*;

  // Object types that the package does not name; they never produce an entry.
  localparam logic [1:0] PDO_BATTERY  = 2'b01;
  localparam logic [1:0] PDO_VARIABLE = 2'b10;

  // Cycles the result side may still be busy after the last expected entry.
  localparam int DRAIN_CYCLES = 4;
  // Cycle limit for the whole run, set well above what the slowest correct run needs.
  localparam int CYCLE_LIMIT  = 400000;

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  pdscd_in_t  in_data;
  logic       out_empty;
  logic       out_pop;
  pdscd_out_t out_data;

  // Decoder state as the byte tracker sees it.
  logic [5:0]  trk_pos;
  logic [2:0]  trk_objects;
  logic [23:0] trk_word;
  logic [3:0]  trk_fixed_used;
  logic [3:0]  trk_pps_used;

  // Entries the block still owes us, oldest first.
  pdscd_out_t pending_entries[$];

  int  err_count;
  int  cycle_count;
  int  useful_bytes;
  int  hold_off_cycles;
  bit  tx_gaps_on;
  bit  rx_stalls_on;

  pd_source_caps_decoder_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Guard against a hung handshake: give up well past the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Turn one completed power data object into an expected entry, if it yields one.
  // Fixed and PPS slots are counted apart; a full table drops the object silently.
  function automatic void decode_pdo(logic [31:0] p, bit last);
    pdscd_out_t e;
    e = '0;
    if (p[31:30] == PDO_FIXED) begin
      if (trk_fixed_used >= SLOT_COUNT) return;
      e.entry_kind     = KIND_FIXED;
      e.slot           = trk_fixed_used[2:0];
      e.voltage_mv     = 16'(int'(p[19:10]) * int'(FIXED_MV_LSB));
      e.max_current_ma = 14'(int'(p[9:0]) * int'(FIXED_MA_LSB));
      e.final_object   = last;
      trk_fixed_used   = trk_fixed_used + 4'd1;
      pending_entries.push_back(e);
    end else if (p[31:30] == PDO_APDO && p[29:28] == APDO_SPR_PPS) begin
      if (trk_pps_used >= SLOT_COUNT) return;
      e.entry_kind     = KIND_PPS;
      e.slot           = trk_pps_used[2:0];
      e.voltage_mv     = 16'(int'(p[24:17]) * int'(PPS_MV_LSB));
      e.min_voltage_mv = 15'(int'(p[15:8]) * int'(PPS_MIN_LSB));
      e.max_current_ma = 14'(int'(p[6:0]) * int'(PPS_MA_LSB));
      e.pps_pwr_lim    = p[27];
      e.final_object   = last;
      trk_pps_used     = trk_pps_used + 4'd1;
      pending_entries.push_back(e);
    end
  endfunction

  // Advance the tracker by one accepted request.
  function automatic void track_buffer_byte(logic [7:0] b, logic st);
    int idx;
    int sub;
    if (st) begin
      // A start always restarts, even in the middle of an object.
      trk_word       = {16'd0, b};
      trk_objects    = '0;
      trk_fixed_used = '0;
      trk_pps_used   = '0;
      trk_pos        = 6'd1;
      return;
    end
    // Idle, or past the end of the buffer: drop the byte, hold the position.
    if (trk_pos == 6'd0 || trk_pos >= BUFFER_BYTES) return;
    if (trk_pos == 6'd1) begin
      trk_objects = b[6:4];
    end else begin
      idx = (int'(trk_pos) - 2) >> 2;
      sub = (int'(trk_pos) - 2) & 3;
      if (idx < int'(trk_objects)) begin
        case (sub)
          0: begin
            trk_word = {16'd0, b};
          end
          1: begin
            trk_word[15:8] = b;
          end
          2: begin
            trk_word[23:16] = b;
          end
          default: begin
            decode_pdo({b, trk_word}, idx + 1 == int'(trk_objects));
          end
        endcase
      end
    end
    trk_pos = trk_pos + 6'd1;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared helpers
  // ---------------------------------------------------------------------------

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap(bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic push_byte(logic [7:0] b, logic st);
    int gap;
    gap = pick_gap(tx_gaps_on);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{byte_value: b, start_req: st};
    do @(posedge clk); while (in_full);
    track_buffer_byte(b, st);
  endtask

  // Two header bytes; the object count sits in bits 6..4 of the second one.
  task automatic send_header(int count);
    logic [7:0] hi;
    hi      = 8'($urandom());
    hi[6:4] = 3'(count);
    push_byte(8'($urandom()), 1'b1);
    push_byte(hi, 1'b0);
    useful_bytes += 2;
  endtask

  // One data object, low byte first.
  task automatic send_pdo(logic [31:0] p);
    for (int i = 0; i < 4; i++) push_byte(p[8*i +: 8], 1'b0);
    useful_bytes += 4;
  endtask

  function automatic logic [31:0] random_pdo();
    logic [31:0] p;
    int r;
    p = $urandom();
    r = $urandom_range(0, 99);
    if (r < 45) begin
      p[31:30] = PDO_FIXED;
    end else if (r < 80) begin
      p[31:30] = PDO_APDO;
      p[29:28] = APDO_SPR_PPS;
    end else if (r < 87) begin
      p[31:30] = PDO_BATTERY;
    end else if (r < 94) begin
      p[31:30] = PDO_VARIABLE;
    end else begin
      // Augmented objects other than SPR PPS give nothing.
      p[31:30] = PDO_APDO;
      p[29:28] = 2'($urandom_range(1, 3));
    end
    return p;
  endfunction

  // Lower the request line and wait until every owed entry has been popped.
  task automatic wait_drained();
    in_push <= 1'b0;
    do @(posedge clk); while (pending_entries.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: pop with random stalls, hold off on demand, check every entry
  // ---------------------------------------------------------------------------
  initial begin : result_checker
    pdscd_out_t want;
    int stall_left;
    stall_left = 0;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && out_empty === 1'b0) begin
        if (pending_entries.size() == 0) begin
          $error("entry popped with none expected: kind %0d slot %0d",
                 out_data.entry_kind, out_data.slot);
          err_count++;
        end else begin
          want = pending_entries.pop_front();
          check_field("entry_kind",     want.entry_kind,     out_data.entry_kind);
          check_field("slot",           want.slot,           out_data.slot);
          check_field("voltage_mv",     want.voltage_mv,     out_data.voltage_mv);
          check_field("min_voltage_mv", want.min_voltage_mv, out_data.min_voltage_mv);
          check_field("max_current_ma", want.max_current_ma, out_data.max_current_ma);
          check_field("pps_pwr_lim",    want.pps_pwr_lim,    out_data.pps_pwr_lim);
          check_field("final_object",   want.final_object,   out_data.final_object);
        end
      end
      // Decide the pop for the next edge: a requested hold-off wins over stalls.
      if (!rst_n) begin
        out_pop <= 1'b0;
      end else if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        stall_left = pick_gap(rx_stalls_on);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every object type but variable, idle bytes, trailing bytes and a restart.
  task automatic test_directed_cases();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    // A byte before any start is dropped.
    push_byte(8'hFF, 1'b0);
    // Fixed with every field at its maximum, then PPS with every field and flag set.
    send_header(2);
    send_pdo(32'h000F_FFFF);
    send_pdo(32'hC9FF_FFFF);
    // Past the counted objects: ignored.
    push_byte(8'h5A, 1'b0);
    // Fixed at zero and a battery object, then a restart in the middle of an object.
    send_header(3);
    send_pdo(32'h0000_0000);
    send_pdo(32'h7FFF_FFFF);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    // PPS at zero, then a non-PPS augmented object with all bits set.
    send_header(2);
    send_pdo(32'hC000_0000);
    send_pdo(32'hFFFF_FFFF);
    wait_drained();
  endtask

  // Hold the result side off long enough for the request queue to fill and
  // stall the input, while the sender keeps offering bytes back to back.
  task automatic test_full_queue_stall();
    logic [31:0] p;
    tx_gaps_on      = 1'b0;
    rx_stalls_on    = 1'b0;
    hold_off_cycles = 80;
    repeat (2) begin
      send_header(7);
      repeat (7) begin
        p        = $urandom();
        p[31:30] = PDO_FIXED;
        send_pdo(p);
      end
    end
    wait_drained();
  endtask

  // One message of random shape: mostly well formed, some cut short, some noise.
  task automatic random_message();
    int count;
    int r;
    int cut;
    logic [31:0] p;
    count = ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 7);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // Noise: loose bytes, now and then with a stray start.
      repeat ($urandom_range(1, 4))
        push_byte(8'($urandom()), $urandom_range(0, 9) == 0);
      return;
    end
    send_header(count);
    if (r < 16 && count > 0) begin
      // Broken: stop partway; the next message's start abandons this one.
      cut = $urandom_range(0, 4 * count - 1);
      for (int i = 0; i < cut; i++) begin
        if ((i & 3) == 0) p = random_pdo();
        push_byte(p[8*(i & 3) +: 8], 1'b0);
      end
      useful_bytes += cut;
      return;
    end
    repeat (count) send_pdo(random_pdo());
    // Trailing bytes; the long runs can reach past the end of the buffer.
    r = $urandom_range(0, 99);
    if (r >= 92)
      repeat ($urandom_range(20, 30)) push_byte(8'($urandom()), 1'b0);
    else if (r >= 70)
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom()), 1'b0);
  endtask

  // Random traffic in four phases covering each mix of sender gaps and receiver stalls.
  task automatic test_random_traffic(int target);
    int goal;
    for (int ph = 0; ph < 4; ph++) begin
      tx_gaps_on   = ph[0];
      rx_stalls_on = ph[1];
      goal = useful_bytes + target / 4;
      while (useful_bytes < goal) random_message();
      // Pause the sender until everything owed has come back.
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    err_count       = 0;
    cycle_count     = 0;
    useful_bytes    = 0;
    hold_off_cycles = 0;
    tx_gaps_on      = 1'b0;
    rx_stalls_on    = 1'b0;
    trk_pos         = '0;
    trk_objects     = '0;
    trk_word        = '0;
    trk_fixed_used  = '0;
    trk_pps_used    = '0;
    in_push <= 1'b0;
    in_data <= '0;
    rst_n   <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_full_queue_stall();
    test_random_traffic(640);

    wait_drained();
    if (pending_entries.size() != 0) begin
      $error("%0d expected entries never arrived", pending_entries.size());
      err_count++;
    end
    if (err_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
